// ===== hw/rtl/k_nearest_heap_select_defines.svh =====
// assertion macros for the k-nearest heap select block
`ifndef K_NEAREST_HEAP_SELECT_DEFINES_SVH
`define K_NEAREST_HEAP_SELECT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define KNHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KNHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/knhs_pkg.sv =====
// types and constants shared by the k-nearest heap select block
`default_nettype none
package knhs_pkg;

  localparam int unsigned DIST_W    = 32;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFFER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_RADIUS = 2'd1;

  localparam logic [CNT_OUT_W-1:0] MAX_COUNT_RST    = 7'd64;
  localparam logic [DIST_W-1:0]    START_RADIUS_RST = '1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIST_W-1:0] cand_dist_sq;
    logic [ID_W-1:0]   cand_id;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]    out_dist_sq;
    logic [ID_W-1:0]      out_id;
    logic [CNT_OUT_W-1:0] found_count;
    logic [DIST_W-1:0]    radius_sq;
    logic                 accepted;
    logic                 last;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_START,
    OP_APPEND,
    OP_BLD_INIT,
    OP_BLD_RD,
    OP_BLD_LD,
    OP_SET_HEAP,
    OP_OFFER_INIT,
    OP_SIFT_RD,
    OP_SIFT_STEP,
    OP_SIFT_FIN,
    OP_SET_RADIUS,
    OP_RO_INIT,
    OP_RO_RD,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_BLD_CHK,
    ST_BLD_LD,
    ST_OFR_CMP,
    ST_SIFT_RD,
    ST_SIFT_STEP,
    ST_SET_RAD,
    ST_EMIT,
    ST_RO_RD,
    ST_RO_OUT
  } state_e;

  typedef struct packed {
    dp_op_e op;
    logic   acc;
    logic   entry;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              le_radius;
    logic              kept_lt_k;
    logic              kept_zero;
    logic              heap_built;
    logic              le_root;
    logic              sift_more;
    logic              sift_stop;
    logic              bld_zero;
    logic              ro_last;
    logic              out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/knhs_dp.sv =====
// datapath: entry memories, heap sift unit, config and output registers
`default_nettype none
module knhs_dp import knhs_pkg::*; #(
  parameter int unsigned K_MAX = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DAT_W-1:0]  cfg_data_i,
  input  wire in_item_t        in_item_i,
  input  wire                  out_ready_i,
  output logic                 out_valid_o,
  output out_item_t            out_item_o,
  input  wire dp_cmd_t         cmd_i,
  output dp_stat_t             stat_o
);

  localparam int unsigned AW    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CW    = $clog2(K_MAX + 1);
  localparam int unsigned PW    = AW + 2;

  logic [DIST_W-1:0] dist_mem [DEPTH];
  logic [ID_W-1:0]   id_mem   [DEPTH];

  logic [CNT_OUT_W-1:0] maxc_q;
  logic [DIST_W-1:0]    srad_q, radius_q, root_q;
  logic [CW-1:0]        kept_q, effk;
  logic                 heap_q;
  in_item_t             in_q;
  logic [AW-1:0]        pos_q, bi_q, ri_q;
  logic [DIST_W-1:0]    sd_q;
  logic [ID_W-1:0]      sid_q;
  logic                 stop_eq_q;
  logic [DIST_W-1:0]    rda_dist_q, rdb_dist_q;
  logic [ID_W-1:0]      rda_id_q, rdb_id_q;
  out_item_t            out_q;
  logic                 out_vld_q;

  logic [PW-1:0]     c1, c2, n_ext;
  logic              c2_ok, pick_b, stop, out_free;
  logic [DIST_W-1:0] dc;
  logic [ID_W-1:0]   idc;
  logic              we, rd_en;
  logic [AW-1:0]     wa, ra, rb;
  logic [DIST_W-1:0] wdist;
  logic [ID_W-1:0]   wid;

  // effective k: zero counts as one, clipped to K_MAX
  always_comb begin
    if (maxc_q == '0) begin
      effk = CW'(1);
    end else if (maxc_q > CNT_OUT_W'(K_MAX)) begin
      effk = CW'(K_MAX);
    end else begin
      effk = CW'(maxc_q);
    end
  end

  assign n_ext  = PW'(kept_q);
  assign c1     = PW'({pos_q, 1'b1});
  assign c2     = c1 + PW'(1);
  assign c2_ok  = c2 < n_ext;
  assign pick_b = c2_ok && (rda_dist_q < rdb_dist_q);
  assign dc     = pick_b ? rdb_dist_q : rda_dist_q;
  assign idc    = pick_b ? rdb_id_q : rda_id_q;
  assign stop   = stop_eq_q ? (sd_q >= dc) : (sd_q > dc);
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    stat_o.mode       = in_q.mode;
    stat_o.le_radius  = in_q.cand_dist_sq <= radius_q;
    stat_o.kept_lt_k  = kept_q < effk;
    stat_o.kept_zero  = kept_q == '0;
    stat_o.heap_built = heap_q;
    stat_o.le_root    = in_q.cand_dist_sq <= root_q;
    stat_o.sift_more  = c1 < n_ext;
    stat_o.sift_stop  = stop;
    stat_o.bld_zero   = bi_q == '0;
    stat_o.ro_last    = (CW'(ri_q) + CW'(1)) == kept_q;
    stat_o.out_free   = out_free;
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    wa    = pos_q;
    wdist = sd_q;
    wid   = sid_q;
    rd_en = 1'b0;
    ra    = c1[AW-1:0];
    rb    = c2[AW-1:0];
    unique case (cmd_i.op)
      OP_APPEND: begin
        we    = 1'b1;
        wa    = AW'(kept_q);
        wdist = in_q.cand_dist_sq;
        wid   = in_q.cand_id;
      end
      OP_SIFT_STEP: begin
        we = 1'b1;
        if (!stop) begin
          wdist = dc;
          wid   = idc;
        end
      end
      OP_SIFT_FIN: we = 1'b1;
      OP_SIFT_RD:  rd_en = 1'b1;
      OP_BLD_RD: begin
        rd_en = 1'b1;
        ra    = bi_q - AW'(1);
      end
      OP_RO_RD: begin
        rd_en = 1'b1;
        ra    = ri_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      dist_mem[wa] <= wdist;
      id_mem[wa]   <= wid;
    end
    if (rd_en) begin
      rda_dist_q <= dist_mem[ra];
      rda_id_q   <= id_mem[ra];
      rdb_dist_q <= dist_mem[rb];
      rdb_id_q   <= id_mem[rb];
    end
    // root mirror of entry zero
    if (we && wa == '0) begin
      root_q <= wdist;
    end
  end

  // sift and index registers, latched item, output item register
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH:    in_q <= in_item_i;
      OP_BLD_INIT: bi_q <= AW'(kept_q >> 1);
      OP_BLD_RD:   bi_q <= bi_q - AW'(1);
      OP_BLD_LD: begin
        sd_q      <= rda_dist_q;
        sid_q     <= rda_id_q;
        pos_q     <= bi_q;
        stop_eq_q <= 1'b1;
      end
      OP_OFFER_INIT: begin
        sd_q      <= in_q.cand_dist_sq;
        sid_q     <= in_q.cand_id;
        pos_q     <= '0;
        stop_eq_q <= 1'b0;
      end
      OP_SIFT_STEP: begin
        if (!stop) begin
          pos_q <= pick_b ? c2[AW-1:0] : c1[AW-1:0];
        end
      end
      OP_RO_INIT: ri_q <= '0;
      OP_EMIT: begin
        if (cmd_i.entry) begin
          ri_q <= ri_q + AW'(1);
        end
      end
      default: ;
    endcase
    if (cmd_i.op == OP_EMIT) begin
      out_q.out_dist_sq <= cmd_i.entry ? rda_dist_q : '0;
      out_q.out_id      <= cmd_i.entry ? rda_id_q : '0;
      out_q.found_count <= CNT_OUT_W'(kept_q);
      out_q.radius_sq   <= radius_q;
      out_q.accepted    <= cmd_i.acc;
      out_q.last        <= cmd_i.entry ? stat_o.ro_last : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxc_q    <= MAX_COUNT_RST;
      srad_q    <= START_RADIUS_RST;
      radius_q  <= START_RADIUS_RST;
      kept_q    <= '0;
      heap_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_idx_i == CFG_MAX_COUNT) begin
          maxc_q <= cfg_data_i[CNT_OUT_W-1:0];
        end else if (cfg_idx_i == CFG_START_RADIUS) begin
          srad_q <= cfg_data_i[DIST_W-1:0];
        end
      end
      unique case (cmd_i.op)
        OP_START: begin
          kept_q   <= '0;
          heap_q   <= 1'b0;
          radius_q <= srad_q;
        end
        OP_APPEND: begin
          kept_q <= kept_q + CW'(1);
          heap_q <= 1'b0;
        end
        OP_SET_HEAP:   heap_q <= 1'b1;
        OP_SET_RADIUS: radius_q <= root_q;
        default: ;
      endcase
      if (cmd_i.op == OP_EMIT) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/knhs_ctrl.sv =====
// controller: sequences append, heap build, sift-down and readout
`default_nettype none
module knhs_ctrl import knhs_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   acc_q, acc_d;
  logic   bld_q, bld_d;

  // next state
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    bld_d   = bld_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        acc_d   = 1'b0;
        state_d = ST_EMIT;
        if (stat_i.mode == MODE_OFFER) begin
          priority if (!stat_i.le_radius) begin
            state_d = ST_EMIT;
          end else if (stat_i.kept_lt_k) begin
            acc_d = 1'b1;
          end else if (stat_i.kept_zero) begin
            state_d = ST_EMIT;
          end else if (!stat_i.heap_built) begin
            state_d = ST_BLD_CHK;
          end else begin
            state_d = ST_OFR_CMP;
          end
        end else if (stat_i.mode == MODE_READ && !stat_i.kept_zero) begin
          state_d = ST_RO_RD;
        end
      end
      ST_BLD_CHK: state_d = stat_i.bld_zero ? ST_OFR_CMP : ST_BLD_LD;
      ST_BLD_LD: begin
        bld_d   = 1'b1;
        state_d = ST_SIFT_RD;
      end
      ST_OFR_CMP: begin
        bld_d   = 1'b0;
        state_d = stat_i.le_root ? ST_SIFT_RD : ST_EMIT;
      end
      ST_SIFT_RD: begin
        if (stat_i.sift_more) begin
          state_d = ST_SIFT_STEP;
        end else begin
          state_d = bld_q ? ST_BLD_CHK : ST_SET_RAD;
        end
      end
      ST_SIFT_STEP: begin
        if (stat_i.sift_stop) begin
          state_d = bld_q ? ST_BLD_CHK : ST_SET_RAD;
        end else begin
          state_d = ST_SIFT_RD;
        end
      end
      ST_SET_RAD: begin
        acc_d   = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_RO_RD: state_d = ST_RO_OUT;
      ST_RO_OUT: begin
        if (stat_i.out_free) begin
          state_d = stat_i.ro_last ? ST_IDLE : ST_RO_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.op    = OP_NOP;
    cmd_o.acc   = acc_q;
    cmd_o.entry = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
        end
      end
      ST_DISP: begin
        if (stat_i.mode == MODE_START) begin
          cmd_o.op = OP_START;
        end else if (stat_i.mode == MODE_OFFER) begin
          priority if (!stat_i.le_radius) begin
            cmd_o.op = OP_NOP;
          end else if (stat_i.kept_lt_k) begin
            cmd_o.op = OP_APPEND;
          end else if (stat_i.kept_zero || stat_i.heap_built) begin
            cmd_o.op = OP_NOP;
          end else begin
            cmd_o.op = OP_BLD_INIT;
          end
        end else if (stat_i.mode == MODE_READ && !stat_i.kept_zero) begin
          cmd_o.op = OP_RO_INIT;
        end
      end
      ST_BLD_CHK:   cmd_o.op = stat_i.bld_zero ? OP_SET_HEAP : OP_BLD_RD;
      ST_BLD_LD:    cmd_o.op = OP_BLD_LD;
      ST_OFR_CMP:   cmd_o.op = stat_i.le_root ? OP_OFFER_INIT : OP_NOP;
      ST_SIFT_RD:   cmd_o.op = stat_i.sift_more ? OP_SIFT_RD : OP_SIFT_FIN;
      ST_SIFT_STEP: cmd_o.op = OP_SIFT_STEP;
      ST_SET_RAD:   cmd_o.op = OP_SET_RADIUS;
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
        end
      end
      ST_RO_RD: cmd_o.op = OP_RO_RD;
      ST_RO_OUT: begin
        cmd_o.acc   = 1'b0;
        cmd_o.entry = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= 1'b0;
      bld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      bld_q   <= bld_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/k_nearest_heap_select.sv =====
// k-nearest heap select: one item at a time; the next item waits for the last one's result.
// an append fills the next free slot; a replace sifts down from the root, level by level.
// an overflow after appends first builds the heap: kept/2 sift-downs, last parent first.
// readout reads, then emits, each entry as the output frees; a sift reads both children at once.
// reset: async active low; empty store, radius and config at reset values, no clearing pass.
`default_nettype none
`include "k_nearest_heap_select_defines.svh"
module k_nearest_heap_select import knhs_pkg::*; #(
  parameter int unsigned K_MAX = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DAT_W-1:0]  cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire in_item_t        in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output out_item_t            out_item_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  knhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  knhs_dp #(
    .K_MAX (K_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  `KNHS_ASSERT_IMP(a_count_bound, out_valid_o, out_item_o.found_count <= CNT_OUT_W'(K_MAX), "kept count above store depth")
  `KNHS_ASSERT_IMP(a_acc_single, out_valid_o && out_item_o.accepted, out_item_o.last, "accepted flag on a readout entry")
  `KNHS_ASSERT_NXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "item taken while previous item still in work")

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the k-nearest heap select block: directed and random queries checked against a local predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import knhs_pkg::*;

  localparam int unsigned KMAX = 64;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;

  k_nearest_heap_select #(.K_MAX(KMAX)) i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_item_i, .out_valid_o, .out_ready_i, .out_item_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [6:0] k_reg;
  logic [31:0] radius_reg;
  logic [31:0] dist_mem [KMAX];
  logic [15:0] id_mem [KMAX];
  int unsigned kept;
  bit heap_ok;
  logic [31:0] radius_now;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int unsigned idle_cycles = 0;
  bit sender_hold = 1'b0;
  int unsigned hold_off_req = 0;

  function automatic void sift(int unsigned pos, logic [31:0] d, logic [15:0] id,
                               int unsigned n, bit stop_eq);
    int unsigned c;
    while (2 * pos + 1 < n) begin
      c = 2 * pos + 1;
      if (c + 1 < n && dist_mem[c] < dist_mem[c + 1]) c++;
      if (stop_eq ? (d >= dist_mem[c]) : (d > dist_mem[c])) break;
      dist_mem[pos] = dist_mem[c];
      id_mem[pos] = id_mem[c];
      pos = c;
    end
    dist_mem[pos] = d;
    id_mem[pos] = id;
  endfunction

  function automatic out_item_t status_result(logic [31:0] d, logic [15:0] id,
                                              bit acc, bit lst);
    out_item_t r;
    r.out_dist_sq = d;
    r.out_id = id;
    r.found_count = kept[6:0];
    r.radius_sq = radius_now;
    r.accepted = acc;
    r.last = lst;
    return r;
  endfunction

  function automatic void predict_selection(in_item_t it);
    int unsigned k;
    int unsigned i;
    bit acc;
    k = (k_reg == 0) ? 1 : (k_reg > KMAX) ? KMAX : k_reg;
    acc = 1'b0;
    case (it.mode)
      MODE_START: begin
        kept = 0;
        heap_ok = 1'b0;
        radius_now = radius_reg;
        expected_results.push_back(status_result('0, '0, 1'b0, 1'b1));
      end
      MODE_OFFER: begin
        if (it.cand_dist_sq <= radius_now) begin
          if (kept < k) begin
            dist_mem[kept] = it.cand_dist_sq;
            id_mem[kept] = it.cand_id;
            kept++;
            heap_ok = 1'b0;
            acc = 1'b1;
          end else if (kept > 0) begin
            if (!heap_ok) begin
              for (i = kept / 2; i > 0; i--) sift(i - 1, dist_mem[i - 1], id_mem[i - 1], kept, 1'b1);
              heap_ok = 1'b1;
            end
            if (it.cand_dist_sq <= dist_mem[0]) begin
              sift(0, it.cand_dist_sq, it.cand_id, kept, 1'b0);
              radius_now = dist_mem[0];
              acc = 1'b1;
            end
          end
        end
        expected_results.push_back(status_result('0, '0, acc, 1'b1));
      end
      MODE_READ: begin
        if (kept == 0) expected_results.push_back(status_result('0, '0, 1'b0, 1'b1));
        for (i = 0; i < kept; i++)
          expected_results.push_back(status_result(dist_mem[i], id_mem[i], 1'b0, i + 1 == kept));
      end
      default: expected_results.push_back(status_result('0, '0, 1'b0, 1'b1));
    endcase
  endfunction

  // driver: bursts and gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_selection(in_item_i);
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0 && !sender_hold) begin
          in_valid_i <= 1'b1;
          in_item_i <= pending_items.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor with receiver stall pattern
  int unsigned stall_phase = 0;
  int unsigned hold_cnt = 0;
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation: %p", out_item_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_item_o.out_dist_sq !== e.out_dist_sq) begin
            $error("out_dist_sq exp %0h got %0h", e.out_dist_sq, out_item_o.out_dist_sq);
            errors++;
          end
          if (out_item_o.out_id !== e.out_id) begin
            $error("out_id exp %0h got %0h", e.out_id, out_item_o.out_id);
            errors++;
          end
          if (out_item_o.found_count !== e.found_count) begin
            $error("found_count exp %0d got %0d", e.found_count, out_item_o.found_count);
            errors++;
          end
          if (out_item_o.radius_sq !== e.radius_sq) begin
            $error("radius_sq exp %0h got %0h", e.radius_sq, out_item_o.radius_sq);
            errors++;
          end
          if (out_item_o.accepted !== e.accepted) begin
            $error("accepted exp %0b got %0b", e.accepted, out_item_o.accepted);
            errors++;
          end
          if (out_item_o.last !== e.last) begin
            $error("last exp %0b got %0b", e.last, out_item_o.last);
            errors++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      stall_phase <= stall_phase + 1;
      if (hold_off_req > 0 && hold_cnt == 0) begin
        hold_cnt <= hold_off_req;
        out_ready_i <= 1'b0;
      end else if (hold_cnt > 1) begin
        hold_cnt <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else begin
        hold_cnt <= 0;
        // stretches of full speed, then a stall mix
        out_ready_i <= (stall_phase[7:6] == 2'b01) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MAX_COUNT) k_reg = val[6:0];
    else if (idx == CFG_START_RADIUS) radius_reg = val;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic add_item(logic [1:0] m, logic [31:0] d, logic [15:0] id);
    in_item_t it;
    it.mode = m;
    it.cand_dist_sq = d;
    it.cand_id = id;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_dist(logic [31:0] radius);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return '1;
      2: return radius;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  initial begin
    int unsigned n;
    int unsigned q;
    int unsigned j;
    k_reg = MAX_COUNT_RST;
    radius_reg = START_RADIUS_RST;
    kept = 0;
    heap_ok = 1'b0;
    radius_now = START_RADIUS_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty readout, extremes, equal radius, unused mode
    add_item(MODE_READ, '0, '0);
    add_item(MODE_OFFER, '1, 16'hFFFF);
    add_item(MODE_OFFER, '0, '0);
    add_item(MODE_READ, '0, '0);
    add_item(2'd3, '1, '1);
    wait_drained();
    write_reg(CFG_MAX_COUNT, 3);
    write_reg(CFG_START_RADIUS, 100);
    write_reg(2'd3, 32'h5);
    add_item(MODE_START, '0, '0);
    add_item(MODE_OFFER, 101, 1);
    add_item(MODE_OFFER, 100, 2);
    add_item(MODE_OFFER, 50, 3);
    add_item(MODE_OFFER, 70, 4);
    add_item(MODE_OFFER, 90, 5);
    add_item(MODE_OFFER, 95, 6);
    add_item(MODE_OFFER, 10, 7);
    add_item(MODE_READ, '0, '0);
    wait_drained();
    // raise k after heap build, then lower below kept
    write_reg(CFG_MAX_COUNT, 5);
    add_item(MODE_OFFER, 20, 8);
    add_item(MODE_OFFER, 30, 9);
    add_item(MODE_OFFER, 5, 10);
    add_item(MODE_READ, '0, '0);
    wait_drained();
    write_reg(CFG_MAX_COUNT, 0);
    add_item(MODE_OFFER, 1, 11);
    add_item(MODE_READ, '0, '0);
    wait_drained();
    // random queries under several settings
    n = 0;
    q = 0;
    while (n < 440) begin
      case (q % 5)
        0: write_reg(CFG_MAX_COUNT, 64);
        1: write_reg(CFG_MAX_COUNT, 1);
        2: write_reg(CFG_MAX_COUNT, 127);
        default: write_reg(CFG_MAX_COUNT, $urandom_range(1, 12));
      endcase
      case (q % 3)
        0: write_reg(CFG_START_RADIUS, '1);
        1: write_reg(CFG_START_RADIUS, '0);
        default: write_reg(CFG_START_RADIUS, $urandom_range(100, 1500));
      endcase
      add_item(MODE_START, $urandom(), $urandom());
      for (j = 0; j < $urandom_range(5, 40); j++) begin
        case ($urandom_range(0, 19))
          0: add_item(MODE_READ, $urandom(), $urandom());
          1: add_item(2'd3, $urandom(), $urandom());
          2: add_item(MODE_START, $urandom(), $urandom());
          default: add_item(MODE_OFFER, rand_dist(radius_reg), $urandom());
        endcase
        n++;
      end
      add_item(MODE_READ, '0, '0);
      n += 2;
      // a long receiver hold-off while the sender keeps going
      if (q == 2) hold_off_req = 400;
      if (q == 3) hold_off_req = 0;
      // once the sender waits for every result before going on
      if (q == 5) begin
        wait (pending_items.size() < 10);
        sender_hold = 1'b1;
        wait (!in_valid_i && expected_results.size() == 0);
        sender_hold = 1'b0;
      end
      wait_drained();
      q++;
    end
    wait_drained();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
